FILE: sv/astable_resistance_median_filter_defines.svh
// Assertion macros for the astable resistance median filter.
// Included by the controller and datapath; relies on clk and rst_n in scope.
`ifndef ASTABLE_RESISTANCE_MEDIAN_FILTER_DEFINES_SVH
`define ASTABLE_RESISTANCE_MEDIAN_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ARMF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ARMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ARMF_ASSERT_SAME(lbl, ante, cons, msg)
`define ARMF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/armf_pkg.sv
// Shared types and constants for the astable resistance median filter.
// No dependencies; imported by the controller, datapath and top level.
package armf_pkg;

  localparam int DIV_STEPS = 16;
  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_RB_OHM = 2'd0;
  localparam logic [1:0] REG_MODELED_LOW = 2'd1;
  localparam logic [1:0] REG_LOW_SOURCE = 2'd2;

  localparam logic [29:0] RB_OHM_RESET = 30'd470;
  localparam logic [15:0] RES_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CMP,
    S_DIV,
    S_FILT,
    S_DONE
  } armf_state_t;

  typedef struct packed {
    logic cap;
    logic mul_en;
    logic cmp_en;
    logic div_en;
    logic filt_en;
    logic out_load;
  } armf_cmd_t;

  typedef struct packed {
    logic skip;
    logic out_valid;
  } armf_sts_t;

endpackage

FILE: sv/armf_ctrl.sv
// Controller state machine for the astable resistance median filter.
// Depends on armf_pkg and the assertion macro header.
`include "astable_resistance_median_filter_defines.svh"

module armf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  input  armf_pkg::armf_sts_t  sts,
  output armf_pkg::armf_cmd_t  cmd
);
  import armf_pkg::*;

  armf_state_t state_r;
  armf_state_t state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = sts.skip ? S_FILT : S_CMP;
      end
      S_CMP: begin
        cnt_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FILT;
        end
      end
      S_FILT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_valid || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap = in_valid;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
      end
      S_CMP: begin
        cmd.cmp_en = 1'b1;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
      end
      S_FILT: begin
        cmd.filt_en = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = !sts.out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `ARMF_ASSERT_NEXT(a_accept_starts, cmd.cap, state_r == S_MUL, "Accepted beat did not start work")
  `ARMF_ASSERT_NEXT(a_div_ends, (state_r == S_DIV) && (cnt_r == CNT_W'(DIV_STEPS - 1)), state_r == S_FILT, "Divider did not finish on its last step")
  `ARMF_ASSERT_SAME(a_load_free, cmd.out_load, !sts.out_valid || out_ready, "Result loaded over a waiting beat")

endmodule

FILE: sv/armf_dp.sv
// Datapath for the astable resistance median filter: multiplier, divider,
// per-channel median-of-3 filter and output register. Depends on armf_pkg.
`include "astable_resistance_median_filter_defines.svh"

module armf_dp #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  armf_pkg::armf_cmd_t  cmd,
  output armf_pkg::armf_sts_t  sts,
  input  logic [4:0]           in_channel,
  input  logic [31:0]          in_high_time,
  input  logic [31:0]          in_low_time,
  input  logic [29:0]          rb_ohm,
  input  logic [31:0]          modeled_low_time,
  input  logic                 low_source_measured,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_accepted,
  output logic [15:0]          out_resistance_ohm
);
  import armf_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  function automatic logic [15:0] mid3(input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] c);
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] m;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    m = (hi > c) ? c : hi;
    return (lo > m) ? lo : m;
  endfunction

  logic [63:0] row_mem [NUM_CHANNELS];
  logic [63:0] row_r;
  logic [1:0]  pos_r [NUM_CHANNELS];
  logic [1:0]  fill_r [NUM_CHANNELS];

  logic [CH_W-1:0] ch_r;
  logic [31:0] lref_r;
  logic [31:0] diff_r;
  logic        gt_r;
  logic        reject_r;
  logic        zref_r;
  logic [61:0] prod_r;
  logic [63:0] rem_r;
  logic [47:0] dsh_r;
  logic [15:0] q_r;
  logic        sat_r;
  logic        acc_r;
  logic [15:0] res_r;
  logic        out_valid_r;
  logic        out_acc_r;
  logic [15:0] out_res_r;

  logic [CH_W-1:0] ch_idx;
  logic [31:0] lref;
  logic        reject;
  logic [63:0] num;
  logic        ge;
  logic [15:0] v;
  logic [1:0]  pos;
  logic [1:0]  fill;
  logic [1:0]  pos_nxt;
  logic [1:0]  fill_nxt;
  logic [15:0] w0;
  logic [15:0] w1;
  logic [15:0] w2;
  logic [15:0] filt_val;
  logic [15:0] res_nxt;
  logic        acc_nxt;
  logic        upd;

  assign ch_idx = CH_W'(in_channel);
  assign lref = low_source_measured ? in_low_time : modeled_low_time;
  assign reject = (32'(in_channel) >= NUM_CHANNELS) || (in_high_time == '0) ||
                  (in_low_time == '0);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      ch_r <= ch_idx;
      lref_r <= lref;
      diff_r <= in_high_time - lref;
      gt_r <= in_high_time > lref;
      reject_r <= reject;
      zref_r <= lref == '0;
      row_r <= row_mem[ch_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= rb_ohm * diff_r;
    end
  end

  assign num = {1'b0, prod_r, 1'b0} + 64'(lref_r);
  assign ge = rem_r >= {16'b0, dsh_r};

  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      sat_r <= num >= {15'b0, lref_r, 17'b0};
      rem_r <= num;
      dsh_r <= {lref_r, 16'b0};
      q_r <= '0;
    end else if (cmd.div_en) begin
      if (ge) begin
        rem_r <= rem_r - {16'b0, dsh_r};
      end
      q_r <= {q_r[14:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  always_comb begin
    v = !gt_r ? 16'd0 : (sat_r ? RES_MAX : q_r);
    pos = pos_r[ch_r];
    fill = fill_r[ch_r];
    pos_nxt = (pos == 2'd2) ? 2'd0 : 2'(pos + 2'd1);
    fill_nxt = (fill == 2'd3) ? 2'd3 : 2'(fill + 2'd1);
    w0 = (pos == 2'd0) ? v : row_r[15:0];
    w1 = (pos == 2'd1) ? v : row_r[31:16];
    w2 = (pos == 2'd2) ? v : row_r[47:32];
    filt_val = (fill_nxt == 2'd3) ? mid3(w0, w1, w2) : v;
    upd = cmd.filt_en && !reject_r && !zref_r;
    if (reject_r) begin
      acc_nxt = 1'b0;
      res_nxt = '0;
    end else if (zref_r) begin
      acc_nxt = 1'b1;
      res_nxt = (fill != 2'd0) ? row_r[63:48] : 16'd0;
    end else begin
      acc_nxt = 1'b1;
      res_nxt = filt_val;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      row_mem[ch_r] <= {filt_val, w2, w1, w0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pos_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else if (upd) begin
      pos_r[ch_r] <= pos_nxt;
      fill_r[ch_r] <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.filt_en) begin
      acc_r <= acc_nxt;
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_acc_r <= acc_r;
      out_res_r <= res_r;
    end
  end

  assign sts.skip = reject_r || zref_r;
  assign sts.out_valid = out_valid_r;
  assign out_valid = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_resistance_ohm = out_res_r;

  `ARMF_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid_r, "Loaded result is not shown")
  `ARMF_ASSERT_NEXT(a_reject_zero, cmd.filt_en && reject_r, !acc_r && (res_r == 16'd0), "Rejected beat gave a non-zero result")
  `ARMF_ASSERT_SAME(a_pos_range, upd, pos != 2'd3, "Window write position out of range")

endmodule

FILE: sv/astable_resistance_median_filter.sv
// Top level of the astable resistance median filter: APB register file,
// controller and datapath. Depends on armf_pkg, armf_ctrl and armf_dp.
//
//   Channel  Ports                                  Beat moves
//   input    in_valid/in_ready, in_*                channel, high and low time
//   result   out_valid/out_ready, out_*             accepted flag, resistance
//   config   psel/penable/pwrite/paddr/pwdata/...   one register write or read
//
// A valid beat goes through multiply, compare, the 16-step restoring divide, filter
// and done; a rejected beat or one with a zero low reference skips compare and divide.
// A new beat is accepted in the cycle after the result enters the output register.
// Reset is synchronous and needs no clearing pass; filter state starts empty.
// A result still waiting in the output register holds the next finished beat in
// the final state until it is taken.
module astable_resistance_median_filter #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [4:0]                  in_channel,
  input  logic [31:0]                 in_high_time,
  input  logic [31:0]                 in_low_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_accepted,
  output logic [15:0]                 out_resistance_ohm,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [armf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import armf_pkg::*;

  logic [29:0] rb_ohm_r;
  logic [31:0] modeled_low_r;
  logic        low_source_r;
  logic        wr_en;
  logic [1:0]  reg_idx;
  armf_cmd_t   cmd;
  armf_sts_t   sts;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_ohm_r <= RB_OHM_RESET;
      modeled_low_r <= '0;
      low_source_r <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RB_OHM: begin
          rb_ohm_r <= pwdata[29:0];
        end
        REG_MODELED_LOW: begin
          modeled_low_r <= pwdata;
        end
        REG_LOW_SOURCE: begin
          low_source_r <= pwdata[0];
        end
        default: begin
          low_source_r <= low_source_r;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RB_OHM: begin
        prdata = {2'b0, rb_ohm_r};
      end
      REG_MODELED_LOW: begin
        prdata = modeled_low_r;
      end
      REG_LOW_SOURCE: begin
        prdata = {31'b0, low_source_r};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  armf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  armf_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_channel          (in_channel),
    .in_high_time        (in_high_time),
    .in_low_time         (in_low_time),
    .rb_ohm              (rb_ohm_r),
    .modeled_low_time    (modeled_low_r),
    .low_source_measured (low_source_r),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_accepted        (out_accepted),
    .out_resistance_ohm  (out_resistance_ohm)
  );

endmodule

FILE: tb/tb_astable_resistance_median_filter.sv
// Self-checking testbench for astable_resistance_median_filter: pulse beats go in,
// each result beat is checked against a predictor of the resistance and median filter.
// Depends on armf_pkg and the RTL of the block; needs no files or arguments.
module tb_astable_resistance_median_filter;
  import armf_pkg::*;

  localparam int NUM_CH = 16;
  localparam int HOLD_CYCLES = 24;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_BEATS = 240;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [4:0]  channel;
    logic [31:0] high_time;
    logic [31:0] low_time;
  } pulse_beat_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] resistance_ohm;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [4:0] in_channel = '0;
  logic [31:0] in_high_time = '0;
  logic [31:0] in_low_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_accepted;
  logic [15:0] out_resistance_ohm;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  astable_resistance_median_filter #(.NUM_CHANNELS(NUM_CH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_channel(in_channel),
    .in_high_time(in_high_time), .in_low_time(in_low_time),
    .out_valid(out_valid), .out_ready(out_ready), .out_accepted(out_accepted),
    .out_resistance_ohm(out_resistance_ohm),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  logic [29:0] cfg_rb = RB_OHM_RESET;
  logic [31:0] cfg_modeled_low = '0;
  logic        cfg_low_measured = 1'b0;

  logic [15:0] med_win [NUM_CH][3];
  int          med_pos [NUM_CH];
  int          med_fill [NUM_CH];
  logic [15:0] held_ohm [NUM_CH];
  logic        held_ok [NUM_CH];

  pulse_beat_t pending_beats[$];
  result_t     expected_results[$];
  pulse_beat_t beat_on_bus;
  int beats_issued = 0;
  int beats_accepted = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int src_burst_pct = 0;
  int sink_burst_pct = 0;
  int src_gap = 0;
  int sink_gap = 0;

  function automatic logic [15:0] ra_from_times(logic [29:0] rb, logic [31:0] hi,
                                                logic [31:0] lo);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    if (hi <= lo) return 16'd0;
    num = 64'(rb) * 64'(hi - lo);
    num = (num << 1) + 64'(lo);
    den = 64'(lo) << 1;
    q = num / den;
    return (q > 64'(RES_MAX)) ? RES_MAX : q[15:0];
  endfunction

  function automatic logic [15:0] median_of_three(logic [15:0] a, logic [15:0] b,
                                                  logic [15:0] c);
    logic [15:0] lo_v;
    logic [15:0] hi_v;
    lo_v = (a < b) ? a : b;
    hi_v = (a < b) ? b : a;
    if (c < lo_v) return lo_v;
    if (c > hi_v) return hi_v;
    return c;
  endfunction

  function automatic result_t predict_result(pulse_beat_t b);
    result_t r;
    logic [31:0] lref;
    logic [15:0] ra;
    int ch;
    r.accepted = 1'b0;
    r.resistance_ohm = '0;
    if (b.channel >= NUM_CH || b.high_time == 0 || b.low_time == 0) return r;
    ch = b.channel;
    lref = cfg_low_measured ? b.low_time : cfg_modeled_low;
    if (lref != 0) begin
      ra = ra_from_times(cfg_rb, b.high_time, lref);
      med_win[ch][med_pos[ch]] = ra;
      med_pos[ch] = (med_pos[ch] == 2) ? 0 : med_pos[ch] + 1;
      if (med_fill[ch] < 3) med_fill[ch]++;
      held_ohm[ch] = (med_fill[ch] < 3) ? ra :
                     median_of_three(med_win[ch][0], med_win[ch][1], med_win[ch][2]);
      held_ok[ch] = 1'b1;
    end
    r.accepted = 1'b1;
    r.resistance_ohm = held_ok[ch] ? held_ohm[ch] : 16'd0;
    return r;
  endfunction

  // The driver: a beat leaves the queue only once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_result(beat_on_bus));
        beats_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          beat_on_bus = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_channel <= beat_on_bus.channel;
          in_high_time <= beat_on_bus.high_time;
          in_low_time <= beat_on_bus.low_time;
          if ($urandom_range(0, 99) < src_burst_pct) src_gap = $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_gap = 0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < sink_burst_pct) begin
      sink_gap = $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat arrived with nothing expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_accepted !== want.accepted) begin
          $error("accepted: expected %0d, actual %0d", want.accepted, out_accepted);
          mismatches++;
        end
        if (out_resistance_ohm !== want.resistance_ohm) begin
          $error("resistance_ohm: expected %0d, actual %0d", want.resistance_ohm,
                 out_resistance_ohm);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic add_beat(input logic [4:0] ch, input logic [31:0] hi, input logic [31:0] lo);
    pulse_beat_t b;
    b.channel = ch;
    b.high_time = hi;
    b.low_time = lo;
    pending_beats.push_back(b);
    beats_issued++;
  endtask

  // Mostly plausible pulse pairs aimed at a chosen resistance, with some noise.
  task automatic add_random_beat();
    int kind;
    int target;
    logic [4:0] ch;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] ref_l;
    logic [63:0] span;
    kind = $urandom_range(0, 99);
    ch = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31)) : 5'($urandom_range(0, 15));
    if (kind < 70) begin
      lo = (kind < 35) ? 32'($urandom_range(1, 2000)) : 32'($urandom());
      if (lo == 0) lo = 32'd1;
      ref_l = cfg_low_measured ? lo : cfg_modeled_low;
      target = $urandom_range(0, 70000);
      span = (cfg_rb == 0) ? 64'($urandom_range(0, 1000))
                           : (64'(target) * 64'(ref_l)) / 64'(cfg_rb);
      if ($urandom_range(0, 7) == 0)
        hi = ref_l - 32'($urandom_range(0, 3));
      else if (span > 64'(32'hFFFF_FFFF - ref_l))
        hi = 32'hFFFF_FFFF;
      else
        hi = ref_l + span[31:0];
    end else if (kind < 85) begin
      hi = $urandom();
      lo = $urandom();
    end else if (kind < 93) begin
      hi = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom());
      lo = (hi != 0) ? 32'd0 : 32'($urandom());
    end else begin
      hi = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'd1;
      lo = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'd1;
    end
    add_beat(ch, hi, lo);
  endtask

  task automatic wait_idle();
    while (beats_accepted != beats_issued || expected_results.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_RB_OHM: cfg_rb = val[29:0];
      REG_MODELED_LOW: cfg_modeled_low = val;
      REG_LOW_SOURCE: cfg_low_measured = val[0];
      default: ;
    endcase
  endtask

  initial begin
    logic [31:0] rb_val;
    logic [31:0] low_val;
    for (int c = 0; c < NUM_CH; c++) begin
      med_win[c][0] = '0;
      med_win[c][1] = '0;
      med_win[c][2] = '0;
      med_pos[c] = 0;
      med_fill[c] = 0;
      held_ohm[c] = '0;
      held_ok[c] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    src_burst_pct = 20;
    sink_burst_pct = 10;

    // Reset configuration: the modeled low time is unset, so nothing is filtered yet.
    add_beat(5'd0, 32'd100, 32'd50);
    add_beat(5'd16, 32'd100, 32'd50);
    add_beat(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_beat(5'd1, 32'd0, 32'd50);
    add_beat(5'd2, 32'd50, 32'd0);

    set_reg(REG_MODELED_LOW, 32'd1000);
    add_beat(5'd0, 32'd1470, 32'd7);
    add_beat(5'd0, 32'd500, 32'd1);
    add_beat(5'd0, 32'hFFFF_FFFF, 32'd1);

    set_reg(REG_LOW_SOURCE, 32'd1);
    add_beat(5'd3, 32'd5, 32'd4);
    add_beat(5'd3, 32'd4, 32'd4);
    add_beat(5'd3, 32'hFFFF_FFFF, 32'd1);
    add_beat(5'd3, 32'd3, 32'd4);
    add_beat(5'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_beat(5'd15, 32'hFFFF_FFFF, 32'd1);

    set_reg(REG_RB_OHM, 32'd0);
    add_beat(5'd4, 32'd1000, 32'd1);

    set_reg(REG_RB_OHM, 32'h3FFF_FFFF);
    add_beat(5'd5, 32'd2, 32'd1);
    add_beat(5'd5, 32'h8000_0000, 32'h7FFF_FFFF);

    set_reg(REG_LOW_SOURCE, 32'd0);
    set_reg(REG_MODELED_LOW, 32'd0);
    add_beat(5'd5, 32'd100, 32'd50);
    set_reg(REG_UNUSED, 32'hFFFF_FFFF);
    add_beat(5'd5, 32'd100, 32'd50);

    set_reg(REG_MODELED_LOW, 32'hFFFF_FFFF);
    add_beat(5'd6, 32'hFFFF_FFFF, 32'd5);

    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 5))
        0: rb_val = 32'd0;
        1: rb_val = 32'd1;
        2: rb_val = 32'h3FFF_FFFF;
        3: rb_val = 32'($urandom());
        default: rb_val = 32'($urandom_range(1, 100000));
      endcase
      case ($urandom_range(0, 5))
        0: low_val = 32'd0;
        1: low_val = 32'd1;
        2: low_val = 32'hFFFF_FFFF;
        3: low_val = 32'($urandom());
        default: low_val = 32'($urandom_range(1, 5000));
      endcase
      set_reg(REG_RB_OHM, rb_val);
      set_reg(REG_MODELED_LOW, low_val);
      set_reg(REG_LOW_SOURCE, (phase % 2 == 0) ? 32'($urandom()) : 32'($urandom()) | 32'd1);
      if (phase == 5) begin
        src_burst_pct = 0;
        sink_burst_pct = 0;
      end else begin
        src_burst_pct = (phase == 2) ? 0 : $urandom_range(5, 40);
        sink_burst_pct = (phase == 1) ? 0 : $urandom_range(2, 20);
      end
      for (int n = 0; n < PHASE_BEATS; n++) add_random_beat();
    end

    wait_idle();
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
